/* src/bsc_pkg.sv */
`default_nettype none
package bsc_pkg;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIVS,
        ALU_DIVU
    } alu_mode_t;

    typedef struct packed {
        logic      go;
        alu_mode_t mode;
    } alu_req_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_MUL,
        S_T_DIV,
        S_P_SQ,
        S_P_X1A,
        S_P_X2A,
        S_P_X1B,
        S_P_X2B,
        S_P_B4,
        S_P_B7,
        S_P_DIV,
        S_P_PP,
        S_P_X1C,
        S_P_X2C
    } st_t;

    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4,
        REG_OSS     = 3'd5
    } reg_idx_t;

    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    localparam logic [31:0] C_B6_OFS   = 32'd4000;
    localparam logic [31:0] C_B4_OFS   = 32'd32768;
    localparam logic [31:0] C_B7_SCALE = 32'd50000;
    localparam logic [31:0] C_P_K1     = 32'd3038;
    localparam logic [31:0] C_P_K2     = 32'hFFFF_E343;
    localparam logic [31:0] C_P_K3     = 32'd3791;
    localparam logic [31:0] C_T_RND    = 32'd8;
    localparam logic [31:0] C_RND2     = 32'd2;

    // Signed division by 2^k that truncates toward zero.
    function automatic logic [31:0] sdp(input logic [31:0] v, input logic [4:0] k);
        logic [31:0] mask;
        logic [31:0] t;
        mask = (32'd1 << k) - 32'd1;
        t = v + (v[31] ? mask : 32'd0);
        return 32'($signed(t) >>> k);
    endfunction

endpackage
`default_nettype wire

/* src/bsc_alu.sv */
`default_nettype none
module bsc_alu (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bsc_pkg::alu_req_t req,
    input  wire logic [31:0]       opa,
    input  wire logic [31:0]       opb,
    output logic [31:0]            res,
    output logic                   busy
);

    logic [31:0]        acc_reg, acc_next;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        b_reg, b_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               neg_reg, neg_next;
    bsc_pkg::alu_mode_t mode_reg, mode_next;

    logic [32:0] sh;
    logic [32:0] diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= bsc_pkg::ALU_MUL;
            neg_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
            neg_reg  <= neg_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        mode_next = mode_reg;
        sh        = {acc_reg, a_reg[31]};
        diff      = sh - {1'b0, b_reg};
        if (req.go) begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            mode_next = req.mode;
            acc_next  = '0;
            neg_next  = 1'b0;
            a_next    = opa;
            b_next    = opb;
            if (req.mode == bsc_pkg::ALU_DIVS) begin
                a_next   = opa[31] ? (32'd0 - opa) : opa;
                b_next   = opb[31] ? (32'd0 - opb) : opb;
                neg_next = opa[31] ^ opb[31];
            end
        end else if (busy_reg) begin
            if (mode_reg == bsc_pkg::ALU_MUL) begin
                acc_next = acc_reg + (b_reg[0] ? a_reg : 32'd0);
                a_next   = {a_reg[30:0], 1'b0};
                b_next   = {1'b0, b_reg[31:1]};
            end else if (!diff[32]) begin
                acc_next = diff[31:0];
                a_next   = {a_reg[30:0], 1'b1};
            end else begin
                acc_next = sh[31:0];
                a_next   = {a_reg[30:0], 1'b0};
            end
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_comb begin
        if (mode_reg == bsc_pkg::ALU_MUL) begin
            res = acc_reg;
        end else begin
            res = neg_reg ? (32'd0 - a_reg) : a_reg;
        end
    end

    assign busy = busy_reg;

endmodule
`default_nettype wire

/* src/barometric_sensor_compensation.sv */
`default_nettype none
// Compensates raw barometric sensor readings with the integer method and ten calibration
// words set over the register port. Every multiplication and division runs through one
// shared bit-serial unit that takes one bit a cycle. A temperature item (tuser 0) needs
// two operations and a pressure item (tuser 1) needs eleven; either ends early with an
// error status and value zero when its divisor is zero. One item is worked on at a time;
// a new item is taken as soon as the previous one has been placed in the output register.
module barometric_sensor_compensation (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // raw_reading
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // value
    output logic [1:0]       m_tuser,   // result_kind, status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;
    bsc_pkg::st_t st_reg, st_next;
    logic        wait_reg, wait_next;
    logic [31:0] b5_reg, b5_next;
    logic [31:0] b6_reg, b6_next;
    logic [31:0] sq_reg, sq_next;
    logic [31:0] x1_reg, x1_next;
    logic [31:0] x2_reg, x2_next;
    logic [31:0] b3_reg, b3_next;
    logic [31:0] b4_reg, b4_next;
    logic [31:0] b7_reg, b7_next;
    logic [31:0] p_reg, p_next;
    logic [15:0] ut_reg, ut_next;
    logic [23:0] up_reg, up_next;
    logic        ov_reg, ov_next;
    logic [31:0] ovalue_reg, ovalue_next;
    logic        okind_reg, okind_next;
    logic        ostat_reg, ostat_next;

    bsc_pkg::alu_req_t req;
    logic [31:0] opa, opb, res;
    logic        busy, rdy, out_free, wr_en;
    logic [31:0] t1, t2, t3;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    assign ac1 = {{16{ac12_reg[31]}}, ac12_reg[31:16]};
    assign ac2 = {{16{ac12_reg[15]}}, ac12_reg[15:0]};
    assign ac3 = {{16{ac34_reg[31]}}, ac34_reg[31:16]};
    assign ac4 = {16'd0, ac34_reg[15:0]};
    assign ac5 = {16'd0, ac56_reg[31:16]};
    assign ac6 = {16'd0, ac56_reg[15:0]};
    assign b1  = {{16{b12_reg[31]}}, b12_reg[31:16]};
    assign b2  = {{16{b12_reg[15]}}, b12_reg[15:0]};
    assign mc  = {{16{mcmd_reg[31]}}, mcmd_reg[31:16]};
    assign md  = {{16{mcmd_reg[15]}}, mcmd_reg[15:0]};

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac12_reg <= '0;
            ac34_reg <= '0;
            ac56_reg <= '0;
            b12_reg  <= '0;
            mcmd_reg <= '0;
            oss_reg  <= 2'd3;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                bsc_pkg::REG_AC1_AC2: ac12_reg <= pwdata;
                bsc_pkg::REG_AC3_AC4: ac34_reg <= pwdata;
                bsc_pkg::REG_AC5_AC6: ac56_reg <= pwdata;
                bsc_pkg::REG_B1_B2:   b12_reg  <= pwdata;
                bsc_pkg::REG_MC_MD:   mcmd_reg <= pwdata;
                bsc_pkg::REG_OSS:     oss_reg  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            bsc_pkg::REG_AC1_AC2: prdata = ac12_reg;
            bsc_pkg::REG_AC3_AC4: prdata = ac34_reg;
            bsc_pkg::REG_AC5_AC6: prdata = ac56_reg;
            bsc_pkg::REG_B1_B2:   prdata = b12_reg;
            bsc_pkg::REG_MC_MD:   prdata = mcmd_reg;
            bsc_pkg::REG_OSS:     prdata = {30'd0, oss_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= bsc_pkg::S_IDLE;
            wait_reg <= 1'b0;
            ov_reg   <= 1'b0;
            b5_reg   <= '0;
        end else begin
            st_reg   <= st_next;
            wait_reg <= wait_next;
            ov_reg   <= ov_next;
            b5_reg   <= b5_next;
        end
        b6_reg     <= b6_next;
        sq_reg     <= sq_next;
        x1_reg     <= x1_next;
        x2_reg     <= x2_next;
        b3_reg     <= b3_next;
        b4_reg     <= b4_next;
        b7_reg     <= b7_next;
        p_reg      <= p_next;
        ut_reg     <= ut_next;
        up_reg     <= up_next;
        ovalue_reg <= ovalue_next;
        okind_reg  <= okind_next;
        ostat_reg  <= ostat_next;
    end

    assign s_tready = (st_reg == bsc_pkg::S_IDLE);
    assign rdy      = wait_reg && !busy;
    assign out_free = !ov_reg || m_tready;

    always_comb begin
        st_next     = st_reg;
        wait_next   = wait_reg;
        b5_next     = b5_reg;
        b6_next     = b6_reg;
        sq_next     = sq_reg;
        x1_next     = x1_reg;
        x2_next     = x2_reg;
        b3_next     = b3_reg;
        b4_next     = b4_reg;
        b7_next     = b7_reg;
        p_next      = p_reg;
        ut_next     = ut_reg;
        up_next     = up_reg;
        ov_next     = ov_reg && !m_tready;
        ovalue_next = ovalue_reg;
        okind_next  = okind_reg;
        ostat_next  = ostat_reg;
        opa         = '0;
        opb         = '0;
        req.mode    = bsc_pkg::ALU_MUL;
        req.go      = (st_reg != bsc_pkg::S_IDLE) && !wait_reg;
        t1          = '0;
        t2          = '0;
        t3          = '0;
        if (req.go) begin
            wait_next = 1'b1;
        end
        unique case (st_reg)
            bsc_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == bsc_pkg::KIND_TEMP) begin
                        ut_next = s_tdata[15:0];
                        st_next = bsc_pkg::S_T_MUL;
                    end else begin
                        up_next = s_tdata >> (4'd8 - {2'd0, oss_reg});
                        b6_next = b5_reg - bsc_pkg::C_B6_OFS;
                        st_next = bsc_pkg::S_P_SQ;
                    end
                end
            end
            bsc_pkg::S_T_MUL: begin
                opa = {16'd0, ut_reg} - ac6;
                opb = ac5;
                if (rdy) begin
                    t1 = bsc_pkg::sdp(res, 5'd15);
                    t2 = t1 + md;
                    if (t2 != 32'd0) begin
                        x1_next   = t1;
                        x2_next   = t2;
                        wait_next = 1'b0;
                        st_next   = bsc_pkg::S_T_DIV;
                    end else if (out_free) begin
                        ov_next     = 1'b1;
                        okind_next  = bsc_pkg::KIND_TEMP;
                        ovalue_next = '0;
                        ostat_next  = 1'b1;
                        wait_next   = 1'b0;
                        st_next     = bsc_pkg::S_IDLE;
                    end
                end
            end
            bsc_pkg::S_T_DIV: begin
                req.mode = bsc_pkg::ALU_DIVS;
                opa = mc << 11;
                opb = x2_reg;
                if (rdy && out_free) begin
                    t1          = x1_reg + res;
                    b5_next     = t1;
                    ov_next     = 1'b1;
                    okind_next  = bsc_pkg::KIND_TEMP;
                    ovalue_next = bsc_pkg::sdp(t1 + bsc_pkg::C_T_RND, 5'd4);
                    ostat_next  = 1'b0;
                    wait_next   = 1'b0;
                    st_next     = bsc_pkg::S_IDLE;
                end
            end
            bsc_pkg::S_P_SQ: begin
                opa = b6_reg;
                opb = b6_reg;
                if (rdy) begin
                    sq_next   = bsc_pkg::sdp(res, 5'd12);
                    wait_next = 1'b0;
                    st_next   = bsc_pkg::S_P_X1A;
                end
            end
            bsc_pkg::S_P_X1A: begin
                opa = b2;
                opb = sq_reg;
                if (rdy) begin
                    x1_next   = bsc_pkg::sdp(res, 5'd11);
                    wait_next = 1'b0;
                    st_next   = bsc_pkg::S_P_X2A;
                end
            end
            bsc_pkg::S_P_X2A: begin
                opa = ac2;
                opb = b6_reg;
                if (rdy) begin
                    t1        = x1_reg + bsc_pkg::sdp(res, 5'd11);
                    t2        = ((ac1 << 2) + t1) << oss_reg;
                    b3_next   = bsc_pkg::sdp(t2 + bsc_pkg::C_RND2, 5'd2);
                    wait_next = 1'b0;
                    st_next   = bsc_pkg::S_P_X1B;
                end
            end
            bsc_pkg::S_P_X1B: begin
                opa = ac3;
                opb = b6_reg;
                if (rdy) begin
                    x1_next   = bsc_pkg::sdp(res, 5'd13);
                    wait_next = 1'b0;
                    st_next   = bsc_pkg::S_P_X2B;
                end
            end
            bsc_pkg::S_P_X2B: begin
                opa = b1;
                opb = sq_reg;
                if (rdy) begin
                    t1        = x1_reg + bsc_pkg::sdp(res, 5'd16) + bsc_pkg::C_RND2;
                    x2_next   = bsc_pkg::sdp(t1, 5'd2) + bsc_pkg::C_B4_OFS;
                    wait_next = 1'b0;
                    st_next   = bsc_pkg::S_P_B4;
                end
            end
            bsc_pkg::S_P_B4: begin
                opa = ac4;
                opb = x2_reg;
                if (rdy) begin
                    b4_next   = res >> 15;
                    wait_next = 1'b0;
                    st_next   = bsc_pkg::S_P_B7;
                end
            end
            bsc_pkg::S_P_B7: begin
                opa = {8'd0, up_reg} - b3_reg;
                opb = bsc_pkg::C_B7_SCALE >> oss_reg;
                if (rdy) begin
                    b7_next = res;
                    if (b4_reg != 32'd0) begin
                        wait_next = 1'b0;
                        st_next   = bsc_pkg::S_P_DIV;
                    end else if (out_free) begin
                        ov_next     = 1'b1;
                        okind_next  = bsc_pkg::KIND_PRESS;
                        ovalue_next = '0;
                        ostat_next  = 1'b1;
                        wait_next   = 1'b0;
                        st_next     = bsc_pkg::S_IDLE;
                    end
                end
            end
            bsc_pkg::S_P_DIV: begin
                req.mode = bsc_pkg::ALU_DIVU;
                opa = b7_reg[31] ? b7_reg : (b7_reg << 1);
                opb = b4_reg;
                if (rdy) begin
                    p_next    = b7_reg[31] ? (res << 1) : res;
                    wait_next = 1'b0;
                    st_next   = bsc_pkg::S_P_PP;
                end
            end
            bsc_pkg::S_P_PP: begin
                opa = bsc_pkg::sdp(p_reg, 5'd8);
                opb = bsc_pkg::sdp(p_reg, 5'd8);
                if (rdy) begin
                    x1_next   = res;
                    wait_next = 1'b0;
                    st_next   = bsc_pkg::S_P_X1C;
                end
            end
            bsc_pkg::S_P_X1C: begin
                opa = x1_reg;
                opb = bsc_pkg::C_P_K1;
                if (rdy) begin
                    x1_next   = bsc_pkg::sdp(res, 5'd16);
                    wait_next = 1'b0;
                    st_next   = bsc_pkg::S_P_X2C;
                end
            end
            bsc_pkg::S_P_X2C: begin
                opa = bsc_pkg::C_P_K2;
                opb = p_reg;
                if (rdy && out_free) begin
                    t1          = bsc_pkg::sdp(res, 5'd16);
                    t2          = x1_reg + t1 + bsc_pkg::C_P_K3;
                    t3          = p_reg + bsc_pkg::sdp(t2, 5'd4);
                    ov_next     = 1'b1;
                    okind_next  = bsc_pkg::KIND_PRESS;
                    ovalue_next = t3;
                    ostat_next  = 1'b0;
                    wait_next   = 1'b0;
                    st_next     = bsc_pkg::S_IDLE;
                end
            end
            default: begin
                st_next = bsc_pkg::S_IDLE;
            end
        endcase
    end

    bsc_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .opa     (opa),
        .opb     (opb),
        .res     (res),
        .busy    (busy)
    );

    assign m_tvalid = ov_reg;
    assign m_tdata  = ovalue_reg;
    assign m_tuser  = {ostat_reg, okind_reg};

endmodule
`default_nettype wire

/* src/bsc_checker.sv */
`default_nettype none
module bsc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 32'd0)
        else $error("error result with nonzero value");

    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
